// ----- src/emgdd_pkg.sv -----
// Shared types, constants and helpers of the EMG differential drive block.
// Depends on nothing; every other file of the block imports it.
package emgdd_pkg;

    localparam int NCH         = 6;
    localparam int MAG_W       = 8;
    localparam int MAG_MAX     = 128;
    localparam int SAMPLE_W    = 8;
    localparam int DRIVE_W     = 16;
    localparam int FRAC_W      = 14;
    localparam int ONE_Q       = 16384;
    localparam int MAX_WINDOW_DEF = 64;

    localparam int WL_W        = 7;
    localparam int DB_W        = 15;
    localparam int SENS_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [WL_W-1:0]   WL_RESET   = WL_W'(50);
    localparam logic [DB_W-1:0]   DB_RESET   = DB_W'(4915);
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(25);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIFF,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;    // beat accepted: latch magnitudes, read oldest entry
        logic update;   // write entry, update sums and pointers
        logic restart;  // window length written: empty the window
    } wctl_t;

    function automatic logic [MAG_W-1:0] rectify(input logic signed [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] v;
        begin
            v = MAG_W'(s);
            rectify = v[MAG_W-1] ? MAG_W'(~v + MAG_W'(1)) : v;
        end
    endfunction

endpackage

// ----- src/emgdd_if.sv -----
// Stream interfaces of the EMG differential drive: sample beats in, drive beats out.
// Depends on emgdd_pkg for field widths.
interface emgdd_sample_if
    import emgdd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch2;
    logic signed [SAMPLE_W-1:0] sample_ch3;
    logic signed [SAMPLE_W-1:0] sample_ch4;
    logic signed [SAMPLE_W-1:0] sample_ch6;
    logic signed [SAMPLE_W-1:0] sample_ch7;

    modport source (output valid, sample_ch0, sample_ch2, sample_ch3, sample_ch4,
                    sample_ch6, sample_ch7, input ready);
    modport sink   (input valid, sample_ch0, sample_ch2, sample_ch3, sample_ch4,
                    sample_ch6, sample_ch7, output ready);
endinterface

interface emgdd_result_if
    import emgdd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      warming;

    modport source (output valid, drive, warming, input ready);
    modport sink   (input valid, drive, warming, output ready);
endinterface

// ----- src/emgdd_window.sv -----
// Sample ring, per-channel running sums, fill count and write pointer.
// Depends on emgdd_pkg.
module emgdd_window
    import emgdd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int NW         = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W      = $clog2(MAX_WINDOW * MAG_MAX + 1)
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  wctl_t                       ctl,
    input  logic [NW-1:0]               n,
    input  logic [NCH-1:0][MAG_W-1:0]   mags,
    output logic [NCH-1:0][SUM_W-1:0]   sums,
    output logic                        full
);
    localparam int PTR_W = $clog2(MAX_WINDOW);

    logic [NCH-1:0][MAG_W-1:0] mem [MAX_WINDOW];
    logic [NCH-1:0][MAG_W-1:0] old_reg;
    logic [NCH-1:0][MAG_W-1:0] mags_reg;
    logic [NCH-1:0][SUM_W-1:0] sums_reg, sums_next;
    logic [NW-1:0]             fill_reg;
    logic [PTR_W-1:0]          wp_reg, wp_cur_reg, wp_eff, wp_adv;
    logic [NW-1:0]             wp_inc;
    logic                      full_now;

    // Guard the pointer against a shrunk window
    always_comb
    begin
        wp_eff = (NW'(wp_reg) >= n) ? '0 : wp_reg;
        wp_inc = NW'(wp_cur_reg) + NW'(1);
        wp_adv = (wp_inc >= n) ? '0 : PTR_W'(wp_inc);
    end

    assign full_now = (fill_reg >= n);

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            sums_next[i] = sums_reg[i] + SUM_W'(mags_reg[i])
                           - (full_now ? SUM_W'(old_reg[i]) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            old_reg    <= mem[wp_eff];
            mags_reg   <= mags;
            wp_cur_reg <= wp_eff;
        end
        if (ctl.update)
        begin
            mem[wp_cur_reg] <= mags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
        end
        else if (ctl.restart)
        begin
            sums_reg <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
        end
        else if (ctl.update)
        begin
            sums_reg <= sums_next;
            wp_reg   <= wp_adv;
            if (!full_now)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
        end
    end

    assign sums = sums_reg;
    assign full = full_now;

endmodule

// ----- src/emgdd_divider.sv -----
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// Depends on emgdd_pkg (style only; no types used beyond the import).
module emgdd_divider
    import emgdd_pkg::*;
#(
    parameter int DVD_W = 30,
    parameter int DVS_W = 19
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(DVD_W - 1));
    assign quotient = quo_reg;

endmodule

// ----- src/emg_differential_drive.sv -----
// EMG differential drive: rectified moving average, scaled difference, deadband, clamp.
// Steps: the sample beat is taken in IDLE, then UPDATE, DIFF, DIVIDE and FINISH, then the output register;
// the bit-serial divider gives one quotient bit a cycle; while warming DIVIDE is skipped (no divide).
// One sample beat at a time: a new beat is taken only once the last result is in the output register.
// Reset: window empty, registers at 50 / 4915 / 25; the sample ring needs no clearing.
module emg_differential_drive
    import emgdd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    emgdd_sample_if.sink          samples,
    emgdd_result_if.source        result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    // Width plan: window count, channel sums, three-channel totals, dividend, divisor
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = $clog2(MAX_WINDOW * MAG_MAX + 1);
    localparam int TRI_W = SUM_W + 2;
    localparam int DVD_W = TRI_W + FRAC_W;
    localparam int DVS_W = NW + SENS_W + 2;
    localparam int PRD_W = NW + SENS_W;

    // Configuration registers
    logic [WL_W-1:0]   wl_reg;
    logic [DB_W-1:0]   db_reg;
    logic [SENS_W-1:0] sens_reg;

    // Sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [DVS_W-1:0]  divisor_reg;
    logic              neg_reg;
    logic              warm_reg;
    logic              out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic              warming_reg;

    logic [NW-1:0]     n;
    logic [NW+WL_W-1:0] wl_ext;
    logic [SENS_W-1:0] sens_eff;
    logic [PRD_W-1:0]  prod;
    logic [DVS_W-1:0]  divisor_next;

    wctl_t                       wctl;
    logic [NCH-1:0][MAG_W-1:0]   mags;
    logic [NCH-1:0][SUM_W-1:0]   sums;
    logic                        full;

    logic [TRI_W-1:0]  pos, neg, diff;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  dividend, quotient;

    logic [DVD_W-1:0]  mag_db;
    logic [DRIVE_W-1:0] mag_clamped;
    logic signed [DRIVE_W-1:0] drive_next;

    logic sample_beat, result_beat, out_free;

    assign sample_beat = samples.valid && samples.ready;
    assign result_beat = result.valid && result.ready;
    assign out_free    = !out_valid_reg || result.ready;

    // Effective window: zero counts as one, saturate at the ring depth
    always_comb
    begin
        wl_ext = (NW + WL_W)'(wl_reg);
        if (wl_reg == '0)
        begin
            n = NW'(1);
        end
        else if (wl_ext > (NW + WL_W)'(MAX_WINDOW))
        begin
            n = NW'(MAX_WINDOW);
        end
        else
        begin
            n = NW'(wl_reg);
        end
    end

    // Divisor 3 * n * sensitivity, registered during the update step
    always_comb
    begin
        sens_eff     = (sens_reg == '0) ? SENS_W'(1) : sens_reg;
        prod         = PRD_W'(n) * PRD_W'(sens_eff);
        divisor_next = (DVS_W'(prod) << 1) + DVS_W'(prod);
    end

    // Rectified magnitudes, channel order 0, 2, 3, 4, 6, 7
    always_comb
    begin
        mags[0] = rectify(samples.sample_ch0);
        mags[1] = rectify(samples.sample_ch2);
        mags[2] = rectify(samples.sample_ch3);
        mags[3] = rectify(samples.sample_ch4);
        mags[4] = rectify(samples.sample_ch6);
        mags[5] = rectify(samples.sample_ch7);
    end

    // Differential of the two channel groups, as sign and magnitude
    always_comb
    begin
        pos      = TRI_W'(sums[1]) + TRI_W'(sums[2]) + TRI_W'(sums[3]);
        neg      = TRI_W'(sums[0]) + TRI_W'(sums[4]) + TRI_W'(sums[5]);
        diff     = (neg > pos) ? (neg - pos) : (pos - neg);
        dividend = DVD_W'(diff) << FRAC_W;
    end

    // Deadband: below drops to zero, exactly at passes, above loses the threshold; then clamp and sign
    always_comb
    begin
        if (quotient < DVD_W'(db_reg))
        begin
            mag_db = '0;
        end
        else if (quotient > DVD_W'(db_reg))
        begin
            mag_db = quotient - DVD_W'(db_reg);
        end
        else
        begin
            mag_db = quotient;
        end
        mag_clamped = (mag_db > DVD_W'(ONE_Q)) ? DRIVE_W'(ONE_Q) : DRIVE_W'(mag_db);
        if (warm_reg)
        begin
            drive_next = '0;
        end
        else if (neg_reg)
        begin
            drive_next = -$signed(mag_clamped);
        end
        else
        begin
            drive_next = $signed(mag_clamped);
        end
    end

    // Sequencer: next state and step strobes
    always_comb
    begin
        state_next     = state_reg;
        wctl.start     = 1'b0;
        wctl.update    = 1'b0;
        wctl.restart   = cfg_we && (cfg_index == CFG_WINDOW_LENGTH);
        div_start      = 1'b0;
        samples.ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    wctl.start = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                wctl.update = 1'b1;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                // Skip the divide while the window is still filling
                if (full)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= WL_RESET;
            db_reg   <= DB_RESET;
            sens_reg <= SENS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: wl_reg   <= cfg_data[WL_W-1:0];
                CFG_DEADBAND:      db_reg   <= cfg_data[DB_W-1:0];
                CFG_SENSITIVITY:   sens_reg <= cfg_data[SENS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Datapath registers: divisor, sign and warming flag of the current beat
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            divisor_reg <= divisor_next;
        end
        if (state_reg == ST_DIFF)
        begin
            neg_reg  <= (neg > pos);
            warm_reg <= !full;
        end
    end

    // Output register: hold the result until the sink takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_beat)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            drive_reg   <= drive_next;
            warming_reg <= warm_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.drive   = drive_reg;
    assign result.warming = warming_reg;

    emgdd_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .NW         (NW),
        .SUM_W      (SUM_W)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (wctl),
        .n     (n),
        .mags  (mags),
        .sums  (sums),
        .full  (full)
    );

    emgdd_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule
